>>> sv/pbfa_pkg.sv
`default_nettype none

package pbfa_pkg;

    // Sizes of the managed region and of the result counters
    localparam int MAX_PAGES    = 256;
    localparam int COUNTER_BITS = 32;

    // Field widths of the request and result channels
    localparam int PAGE_W  = 9;
    localparam int GRANT_W = 8;
    localparam int STAT_W  = 2;
    localparam int ADDR_W  = PAGE_W + 1;

    // Bitmap organisation: one word is scanned per cycle
    localparam int WORD_BITS = 16;
    localparam int N_WORDS   = MAX_PAGES / WORD_BITS;
    localparam int WIDX_W    = $clog2(N_WORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);

    // Request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_ROOM   = 2'd1,
        ST_OUTSIDE   = 2'd2,
        ST_BAD_RANGE = 2'd3
    } t_status;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              load;
        logic              check;
        logic              fit;
        logic              prep;
        logic              upd;
        logic              publish;
        logic [WIDX_W-1:0] widx;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic go_fit;
        logic found;
    } t_sts;

endpackage

`default_nettype wire

>>> sv/pbfa_req_if.sv
`default_nettype none

interface pbfa_req_if import pbfa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [PAGE_W-1:0] page_count;
    logic [PAGE_W-1:0] start_page;

    modport source (output valid, output req_type, output page_count, output start_page,
                    input ready);
    modport sink   (input valid, input req_type, input page_count, input start_page,
                    output ready);
endinterface

`default_nettype wire

>>> sv/pbfa_rsp_if.sv
`default_nettype none

interface pbfa_rsp_if import pbfa_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic [GRANT_W-1:0]      granted_page;
    logic [PAGE_W-1:0]       pages_in_use;
    logic [PAGE_W-1:0]       largest_free_run;
    logic [COUNTER_BITS-1:0] alloc_total;
    logic [COUNTER_BITS-1:0] free_total;

    modport source (output valid, output status, output granted_page, output pages_in_use,
                    output largest_free_run, output alloc_total, output free_total,
                    input ready);
    modport sink   (input valid, input status, input granted_page, input pages_in_use,
                    input largest_free_run, input alloc_total, input free_total,
                    output ready);
endinterface

`default_nettype wire

>>> sv/page_bitmap_first_fit_allocator_top.sv
`default_nettype none

// Page allocator over a bitmap of up to 256 pages, all free after reset. A request
// either allocates page_count consecutive pages (first fit from page 0) or frees a
// given run; every request returns one result with status, granted start page,
// pages in use, the longest free run and the success counters. The bitmap is held
// in 16-page words and one word is processed per cycle by a shared run scanner. A
// free passes the check, the commit and the update pass; an allocate that passes
// the room check first runs a first-fit pass (it stops at the word where the run
// completes), and one refused at the room check skips it. One request is worked on
// at a time; the next is accepted while the previous result still waits.

module page_bitmap_first_fit_allocator_top import pbfa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [PAGE_W-1:0] i_cfg_wdata,
    pbfa_req_if.sink          i_req,
    pbfa_rsp_if.source        o_rsp
);

    t_cmd cmd;
    t_sts sts;

    pbfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pbfa_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_req_type         (i_req.req_type),
        .i_page_count       (i_req.page_count),
        .i_start_page       (i_req.start_page),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_status           (o_rsp.status),
        .o_granted_page     (o_rsp.granted_page),
        .o_pages_in_use     (o_rsp.pages_in_use),
        .o_largest_free_run (o_rsp.largest_free_run),
        .o_alloc_total      (o_rsp.alloc_total),
        .o_free_total       (o_rsp.free_total)
    );

endmodule

`default_nettype wire

>>> sv/pbfa_word_scan.sv
`default_nettype none

module pbfa_word_scan import pbfa_pkg::*; (
    input  logic [WORD_BITS-1:0] i_used,
    input  logic [PAGE_W-1:0]    i_run_in,
    input  logic [PAGE_W-1:0]    i_need,
    output logic [PAGE_W-1:0]    o_run_out,
    output logic [PAGE_W-1:0]    o_best,
    output logic                 o_found,
    output logic [BIT_W-1:0]     o_first
);

    logic [PAGE_W-1:0] run  [WORD_BITS];
    logic [PAGE_W-1:0] tree [2*WORD_BITS-1];

    // Length of the free run ending at each bit, counting the carry from earlier words
    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            run[j] = i_run_in + PAGE_W'(j) + PAGE_W'(1);
            for (int k = 0; k <= j; k++) begin
                if (i_used[k]) begin
                    run[j] = PAGE_W'(j - k);
                end
            end
        end
    end

    // Lowest bit at which the run reaches the needed length
    always_comb begin
        o_found = 1'b0;
        o_first = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (run[j] >= i_need) begin
                o_found = 1'b1;
                o_first = BIT_W'(j);
            end
        end
    end

    // Maximum run in the word, through a balanced compare tree
    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            tree[WORD_BITS-1+j] = run[j];
        end
        for (int i = WORD_BITS - 2; i >= 0; i--) begin
            tree[i] = (tree[2*i+1] > tree[2*i+2]) ? tree[2*i+1] : tree[2*i+2];
        end
    end

    assign o_best    = tree[0];
    assign o_run_out = run[WORD_BITS-1];

endmodule

`default_nettype wire

>>> sv/pbfa_ctrl.sv
`default_nettype none

module pbfa_ctrl import pbfa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FIT,
        S_PREP,
        S_UPD,
        S_OUT
    } t_state;

    t_state            r_state;
    logic [WIDX_W-1:0] r_widx;
    logic              r_rsp_valid;
    logic              last_word;
    logic              out_free;

    assign last_word   = (r_widx == WIDX_W'(N_WORDS - 1));
    assign out_free    = !r_rsp_valid || i_rsp_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;

    // Decode commands from the current state
    always_comb begin
        o_cmd         = '0;
        o_cmd.widx    = r_widx;
        o_cmd.load    = (r_state == S_IDLE) && i_req_valid;
        o_cmd.check   = (r_state == S_CHECK);
        o_cmd.fit     = (r_state == S_FIT);
        o_cmd.prep    = (r_state == S_PREP);
        o_cmd.upd     = (r_state == S_UPD);
        o_cmd.publish = (r_state == S_OUT) && out_free;
    end

    // Sequence one request: check, first-fit pass (allocations that pass the check), commit, update pass, publish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_widx      <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (o_cmd.publish) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_widx  <= '0;
                    r_state <= i_sts.go_fit ? S_FIT : S_PREP;
                end
                S_FIT: begin
                    if (i_sts.found || last_word) begin
                        r_widx  <= '0;
                        r_state <= S_PREP;
                    end else begin
                        r_widx <= r_widx + WIDX_W'(1);
                    end
                end
                S_PREP: begin
                    r_widx  <= '0;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (last_word) begin
                        r_state <= S_OUT;
                    end else begin
                        r_widx <= r_widx + WIDX_W'(1);
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/pbfa_datapath.sv
`default_nettype none

module pbfa_datapath import pbfa_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [PAGE_W-1:0]       i_cfg_wdata,
    input  logic                    i_req_type,
    input  logic [PAGE_W-1:0]       i_page_count,
    input  logic [PAGE_W-1:0]       i_start_page,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    output logic [STAT_W-1:0]       o_status,
    output logic [GRANT_W-1:0]      o_granted_page,
    output logic [PAGE_W-1:0]       o_pages_in_use,
    output logic [PAGE_W-1:0]       o_largest_free_run,
    output logic [COUNTER_BITS-1:0] o_alloc_total,
    output logic [COUNTER_BITS-1:0] o_free_total
);

    // Configuration and bookkeeping state
    logic [PAGE_W-1:0]       r_region;
    logic [WORD_BITS-1:0]    r_map [N_WORDS];
    logic [PAGE_W-1:0]       r_used_total;
    logic [COUNTER_BITS-1:0] r_alloc_cnt;
    logic [COUNTER_BITS-1:0] r_free_cnt;

    // Request in progress
    logic                    r_req_type;
    logic [PAGE_W-1:0]       r_count;
    logic [PAGE_W-1:0]       r_start;
    t_status                 r_status;
    logic [GRANT_W-1:0]      r_at;
    logic                    r_apply;
    logic [PAGE_W-1:0]       r_run;
    logic [PAGE_W-1:0]       r_best;

    // Result register
    logic [STAT_W-1:0]       r_o_status;
    logic [GRANT_W-1:0]      r_o_granted;
    logic [PAGE_W-1:0]       r_o_in_use;
    logic [PAGE_W-1:0]       r_o_largest;
    logic [COUNTER_BITS-1:0] r_o_alloc;
    logic [COUNTER_BITS-1:0] r_o_free;

    logic [PAGE_W-1:0]       pages;
    logic [PAGE_W-1:0]       avail;
    logic [ADDR_W-1:0]       free_end;
    t_status                 pre_status;
    logic [ADDR_W-1:0]       base;
    logic [ADDR_W-1:0]       lo;
    logic [ADDR_W-1:0]       hi;
    logic [WORD_BITS-1:0]    cur_word;
    logic [WORD_BITS-1:0]    new_word;
    logic [WORD_BITS-1:0]    out_mask;
    logic [WORD_BITS-1:0]    scan_used;
    logic [PAGE_W-1:0]       scan_run_out;
    logic [PAGE_W-1:0]       scan_best;
    logic                    scan_found;
    logic [BIT_W-1:0]        scan_first;
    logic [ADDR_W-1:0]       fit_start;

    // Clamp the region to the bitmap size
    assign pages = (r_region > PAGE_W'(MAX_PAGES)) ? PAGE_W'(MAX_PAGES) : r_region;
    assign avail = (pages > r_used_total) ? (pages - r_used_total) : '0;
    assign free_end = ADDR_W'(r_start) + ADDR_W'(r_count);

    // Early verdict on the latched request
    always_comb begin
        pre_status = ST_OK;
        if (r_req_type == REQ_ALLOC) begin
            if (r_count == '0 || r_count > avail) begin
                pre_status = ST_NO_ROOM;
            end
        end else begin
            if (r_start >= pages) begin
                pre_status = ST_OUTSIDE;
            end else if (r_count == '0 || free_end > ADDR_W'(pages)) begin
                pre_status = ST_BAD_RANGE;
            end
        end
    end

    assign o_sts.go_fit = (r_req_type == REQ_ALLOC) && (pre_status == ST_OK);
    assign o_sts.found  = i_cmd.fit && scan_found;

    // Word under scan, with pages beyond the region taken as used
    assign base     = ADDR_W'({i_cmd.widx, {BIT_W{1'b0}}});
    assign cur_word = r_map[i_cmd.widx];
    assign lo       = (r_req_type == REQ_ALLOC) ? ADDR_W'(r_at) : ADDR_W'(r_start);
    assign hi       = lo + ADDR_W'(r_count);

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            out_mask[j] = (base + ADDR_W'(j)) >= ADDR_W'(pages);
            new_word[j] = cur_word[j];
            if (r_apply && (base + ADDR_W'(j)) >= lo && (base + ADDR_W'(j)) < hi) begin
                new_word[j] = (r_req_type == REQ_ALLOC);
            end
        end
    end

    assign scan_used = (i_cmd.upd ? new_word : cur_word) | out_mask;

    pbfa_word_scan u_scan (
        .i_used    (scan_used),
        .i_run_in  (r_run),
        .i_need    (r_count),
        .o_run_out (scan_run_out),
        .o_best    (scan_best),
        .o_found   (scan_found),
        .o_first   (scan_first)
    );

    assign fit_start = base + ADDR_W'(scan_first) + ADDR_W'(1) - ADDR_W'(r_count);

    // Bookkeeping state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region     <= PAGE_W'(MAX_PAGES);
            r_used_total <= '0;
            r_alloc_cnt  <= '0;
            r_free_cnt   <= '0;
            for (int w = 0; w < N_WORDS; w++) begin
                r_map[w] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_region <= i_cfg_wdata;
            end
            // Commit counters once the request is known to succeed
            if (i_cmd.prep && r_apply) begin
                if (r_req_type == REQ_ALLOC) begin
                    r_used_total <= r_used_total + r_count;
                    r_alloc_cnt  <= r_alloc_cnt + COUNTER_BITS'(1);
                end else begin
                    r_used_total <= (r_used_total > r_count) ? (r_used_total - r_count) : '0;
                    r_free_cnt   <= r_free_cnt + COUNTER_BITS'(1);
                end
            end
            if (i_cmd.upd) begin
                r_map[i_cmd.widx] <= new_word;
            end
        end
    end

    // Request progress and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_type <= i_req_type;
            r_count    <= i_page_count;
            r_start    <= i_start_page;
        end
        if (i_cmd.check) begin
            r_at    <= '0;
            r_run   <= '0;
            r_apply <= (r_req_type == REQ_FREE) && (pre_status == ST_OK);
            r_status <= (o_sts.go_fit) ? ST_NO_ROOM : pre_status;
        end
        if (i_cmd.fit) begin
            if (scan_found) begin
                r_at     <= fit_start[GRANT_W-1:0];
                r_apply  <= 1'b1;
                r_status <= ST_OK;
            end else begin
                r_run <= scan_run_out;
            end
        end
        if (i_cmd.prep) begin
            r_run  <= '0;
            r_best <= '0;
        end
        if (i_cmd.upd) begin
            r_run  <= scan_run_out;
            r_best <= (scan_best > r_best) ? scan_best : r_best;
        end
        if (i_cmd.publish) begin
            r_o_status  <= r_status;
            r_o_granted <= r_at;
            r_o_in_use  <= r_used_total;
            r_o_largest <= r_best;
            r_o_alloc   <= r_alloc_cnt;
            r_o_free    <= r_free_cnt;
        end
    end

    assign o_status           = r_o_status;
    assign o_granted_page     = r_o_granted;
    assign o_pages_in_use     = r_o_in_use;
    assign o_largest_free_run = r_o_largest;
    assign o_alloc_total      = r_o_alloc;
    assign o_free_total       = r_o_free;

`ifndef SYNTHESIS
    a_grant_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.publish |=> (r_o_status == ST_OK || r_o_granted == '0))
        else $error("granted page set on a failed request");

    a_alloc_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.prep && r_apply && r_req_type == REQ_ALLOC)
        |=> r_alloc_cnt == $past(r_alloc_cnt) + COUNTER_BITS'(1))
        else $error("allocation commit did not advance the counter");

    a_free_no_growth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.prep && r_apply && r_req_type == REQ_FREE)
        |=> r_used_total <= $past(r_used_total))
        else $error("free commit raised the used page total");
`endif

endmodule

`default_nettype wire
